@@ rtl/debe_pkg.sv @@
package debe_pkg;

    // Field widths of the request and response items
    localparam int CMD_W  = 2;
    localparam int ADDR_W = 7;
    localparam int DATA_W = 8;
    localparam int RD_W   = 16;

    // Span of the address field and default segment size
    localparam int ADDR_SPAN         = 128;
    localparam int SEGMENT_BYTES_DEF = 128;

    // Erased byte value and word-alignment address mask
    localparam logic [DATA_W-1:0] ERASED    = 8'hff;
    localparam logic [ADDR_W-1:0] WORD_MASK = 7'h7e;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ_BYTE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_WORD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_BYTE = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // latch the accepted item and the current segment
        logic res_clr;   // start a fresh result
        logic rd_lo;     // read the low (or only) byte
        logic rd_hi;     // read the high byte of a word
        logic cap_lo;    // capture read byte into result low byte
        logic cap_hi;    // capture read byte into result high byte
        logic copy_clr;  // rewind the copy counter
        logic copy_rd;   // read one source byte and advance the copy counter
        logic out_load;  // move the result into the output register
    } debe_ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_read;
        logic is_word;
        logic write_go;
        logic copy_last;
    } debe_stat_t;

endpackage

@@ rtl/debe_req_if.sv @@
interface debe_req_if;
    logic                         valid;
    logic                         ready;
    logic [debe_pkg::CMD_W-1:0]   command;
    logic [debe_pkg::ADDR_W-1:0]  address;
    logic [debe_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, command, address, write_data, input ready);
    modport sink   (input valid, command, address, write_data, output ready);
endinterface

@@ rtl/debe_rsp_if.sv @@
interface debe_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [debe_pkg::RD_W-1:0]  read_data;
    logic                       status;

    modport source (output valid, read_data, status, input ready);
    modport sink   (input valid, read_data, status, output ready);
endinterface

@@ rtl/debe_datapath.sv @@
module debe_datapath #(
    parameter int SEGMENT_BYTES = debe_pkg::SEGMENT_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  debe_pkg::debe_ctl_t          ctl,
    output debe_pkg::debe_stat_t         stat,
    input  logic [debe_pkg::CMD_W-1:0]   in_command,
    input  logic [debe_pkg::ADDR_W-1:0]  in_address,
    input  logic [debe_pkg::DATA_W-1:0]  in_write_data,
    output logic [debe_pkg::RD_W-1:0]    out_read_data,
    output logic                         out_status
);
    import debe_pkg::*;

    localparam int IDX_W = $clog2(SEGMENT_BYTES);
    localparam int CMP_W = 10;
    localparam logic [IDX_W-1:0] VER_IDX = IDX_W'(SEGMENT_BYTES - 1);

    // Segment choice from the two version bytes
    function automatic logic pick_bank(logic [DATA_W-1:0] v0, logic [DATA_W-1:0] v1);
        logic sel;
        sel = 1'b0;
        if (v0 != ERASED && v1 != ERASED) begin
            sel = (v0 < v1);
        end
        else if (v0 == ERASED && v1 == '0) begin
            sel = 1'b1;
        end
        return sel;
    endfunction

    // Flash segments
    logic [DATA_W-1:0] bank0_mem [SEGMENT_BYTES];
    logic [DATA_W-1:0] bank1_mem [SEGMENT_BYTES];

    logic [CMD_W-1:0]  cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;
    logic              cur_reg;
    logic              cur_next;
    logic [DATA_W-1:0] v0_reg;
    logic [DATA_W-1:0] v1_reg;
    logic [1:0]        written_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic              pend_reg;
    logic [DATA_W-1:0] q0_reg;
    logic [DATA_W-1:0] q1_reg;
    logic [DATA_W-1:0] res_lo_reg;
    logic [DATA_W-1:0] res_hi_reg;
    logic              res_st_reg;
    logic [RD_W-1:0]   out_data_reg;
    logic              out_st_reg;

    logic [IDX_W-1:0]  wrap_tab [ADDR_SPAN];
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;
    logic [IDX_W-1:0]  rd_idx;
    logic              rd_en;
    logic              write_ok;
    logic [DATA_W-1:0] rd_byte;
    logic [DATA_W-1:0] ver_new;
    logic              wr_is_ver;
    logic              wr_is_tgt;
    logic [DATA_W-1:0] wr_byte;

    // Fold addresses into the segment
    for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_wrap
        assign wrap_tab[g] = IDX_W'(g % SEGMENT_BYTES);
    end

    // Decode the latched item
    assign write_ok       = (CMP_W'(addr_reg) <= CMP_W'(SEGMENT_BYTES - 2));
    assign stat.is_read   = (cmd_reg == CMD_READ_BYTE) || (cmd_reg == CMD_READ_WORD);
    assign stat.is_word   = (cmd_reg == CMD_READ_WORD);
    assign stat.write_go  = (cmd_reg == CMD_WRITE_BYTE) && write_ok;
    assign stat.copy_last = (cnt_reg == VER_IDX);
    assign cur_next       = pick_bank(v0_reg, v1_reg);

    // Select the read address
    assign lo_addr = stat.is_word ? (addr_reg & WORD_MASK) : addr_reg;
    assign hi_addr = (addr_reg & WORD_MASK) | ADDR_W'(1);
    always_comb
    begin
        if (ctl.copy_rd) begin
            rd_idx = cnt_reg;
        end
        else if (ctl.rd_hi) begin
            rd_idx = wrap_tab[hi_addr];
        end
        else begin
            rd_idx = wrap_tab[lo_addr];
        end
    end
    assign rd_en = ctl.rd_lo | ctl.rd_hi | ctl.copy_rd;

    // A segment never written reads as erased
    assign rd_byte = cur_reg ? (written_reg[1] ? q1_reg : ERASED)
                             : (written_reg[0] ? q0_reg : ERASED);

    // Build the byte for the other segment
    assign ver_new   = (cur_reg ? v1_reg : v0_reg) + DATA_W'(1);
    assign wr_is_ver = (wr_idx_reg == VER_IDX);
    assign wr_is_tgt = (CMP_W'(wr_idx_reg) == CMP_W'(addr_reg));
    assign wr_byte   = wr_is_ver ? ver_new : (wr_is_tgt ? data_reg : rd_byte);

    // Memory ports: write the other segment, read both at one address
    always_ff @(posedge clk)
    begin
        if (pend_reg && cur_reg) begin
            bank0_mem[wr_idx_reg] <= wr_byte;
        end
        if (pend_reg && !cur_reg) begin
            bank1_mem[wr_idx_reg] <= wr_byte;
        end
        if (rd_en) begin
            q0_reg <= bank0_mem[rd_idx];
            q1_reg <= bank1_mem[rd_idx];
        end
    end

    // Track versions, written segments and the pending copy write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v0_reg      <= ERASED;
            v1_reg      <= ERASED;
            written_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else begin
            pend_reg <= ctl.copy_rd;
            if (pend_reg && wr_is_ver) begin
                if (cur_reg) begin
                    v0_reg         <= ver_new;
                    written_reg[0] <= 1'b1;
                end
                else begin
                    v1_reg         <= ver_new;
                    written_reg[1] <= 1'b1;
                end
            end
        end
    end

    // Hold the item, the copy counter and the result
    always_ff @(posedge clk)
    begin
        if (ctl.load) begin
            cmd_reg  <= in_command;
            addr_reg <= in_address;
            data_reg <= in_write_data;
            cur_reg  <= cur_next;
        end
        if (ctl.copy_clr) begin
            cnt_reg <= '0;
        end
        else if (ctl.copy_rd) begin
            cnt_reg    <= cnt_reg + IDX_W'(1);
            wr_idx_reg <= cnt_reg;
        end
        if (ctl.res_clr) begin
            res_lo_reg <= '0;
            res_hi_reg <= '0;
            res_st_reg <= (cmd_reg == CMD_WRITE_BYTE) && !write_ok;
        end
        if (ctl.cap_lo) begin
            res_lo_reg <= rd_byte;
        end
        if (ctl.cap_hi) begin
            res_hi_reg <= rd_byte;
        end
        if (ctl.out_load) begin
            out_data_reg <= {res_hi_reg, res_lo_reg};
            out_st_reg   <= res_st_reg;
        end
    end

    assign out_read_data = out_data_reg;
    assign out_status    = out_st_reg;

`ifndef NO_ASSERTIONS
    ap_no_load_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !ctl.load)
        else $error("new item latched while a copy write is pending");

    ap_written_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(written_reg[0]) && !$fell(written_reg[1]))
        else $error("segment lost its written mark");

    ap_copy_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (CMP_W'(wr_idx_reg) <= CMP_W'(SEGMENT_BYTES - 1)))
        else $error("copy write beyond the segment");
`endif

endmodule

@@ rtl/debe_ctrl.sv @@
module debe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  debe_pkg::debe_stat_t  stat,
    output debe_pkg::debe_ctl_t   ctl
);
    import debe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_LO,
        S_RD_HI,
        S_COPY,
        S_COPY_END,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    // Issue datapath commands for the current state
    always_comb
    begin
        ctl      = '0;
        in_ready = (state_reg == S_IDLE);
        ctl.load = in_valid && in_ready;
        case (state_reg)
            S_DECODE: begin
                ctl.res_clr = 1'b1;
                if (stat.is_read) begin
                    ctl.rd_lo = 1'b1;
                end
                else if (stat.write_go) begin
                    ctl.copy_clr = 1'b1;
                end
            end
            S_RD_LO: begin
                ctl.cap_lo = 1'b1;
                ctl.rd_hi  = stat.is_word;
            end
            S_RD_HI: begin
                ctl.cap_hi = 1'b1;
            end
            S_COPY: begin
                ctl.copy_rd = 1'b1;
            end
            S_FINISH: begin
                ctl.out_load = !out_valid_reg || out_ready;
            end
            default: begin
            end
        endcase
    end

    // Advance state and hold the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (ctl.out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (ctl.load) begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (stat.is_read) begin
                        state_reg <= S_RD_LO;
                    end
                    else if (stat.write_go) begin
                        state_reg <= S_COPY;
                    end
                    else begin
                        state_reg <= S_FINISH;
                    end
                end
                S_RD_LO: begin
                    state_reg <= stat.is_word ? S_RD_HI : S_FINISH;
                end
                S_RD_HI: begin
                    state_reg <= S_FINISH;
                end
                S_COPY: begin
                    if (stat.copy_last) begin
                        state_reg <= S_COPY_END;
                    end
                end
                S_COPY_END: begin
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (ctl.out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    ap_copy_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY) && stat.copy_last |=> (state_reg == S_COPY_END))
        else $error("copy did not stop after the version byte");

    ap_load_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded");

    ap_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("loaded result not presented");
`endif

endmodule

@@ rtl/dual_bank_eeprom_emulator.sv @@
// Small EEPROM emulated over two flash segments used in turn.
// Channel req carries command (read byte, read word, write byte), address
// and write_data; channel rsp returns read_data and status, one item per
// request. Both channels move an item when valid and ready are high.
// A request is taken only while the block is idle. After the decode step a
// read fetches its low byte and, for a word, its high byte; an ignored
// write or an unused command goes straight to the result.
// A write copies the whole current segment into the other one, one byte a
// cycle through a single read port per segment. A new request can be taken
// in the cycle after the previous result is loaded, not before.
// The output register holds a finished result while rsp.ready is low; the
// next request is still accepted and worked, and waits before its result
// is loaded until the register is free.
// Reset returns the block to idle and marks both segments erased (every
// byte reads 0xff) without a clearing pass; a segment becomes valid after
// its first full copy.
module dual_bank_eeprom_emulator #(
    parameter int SEGMENT_BYTES = debe_pkg::SEGMENT_BYTES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    debe_req_if.sink  req,
    debe_rsp_if.source rsp
);
    import debe_pkg::*;

    debe_ctl_t  ctl;
    debe_stat_t stat;

    // Sequence each item
    debe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Hold segments, versions and result
    debe_datapath #(
        .SEGMENT_BYTES (SEGMENT_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .in_command    (req.command),
        .in_address    (req.address),
        .in_write_data (req.write_data),
        .out_read_data (rsp.read_data),
        .out_status    (rsp.status)
    );

endmodule
